### src/rrle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrle_pkg: shared types and constants of the raster RLE video decoder
// Field widths, raster geometry and stream byte codes.
// ----------------------------------------------------------------------------
package rrle_pkg;

  // Field and state widths
  localparam int BYTE_W = 8;
  localparam int OFF_W  = 22;
  localparam int LEN_W  = 11;
  localparam int COL_W  = 7;
  localparam int RC_W   = 17;
  localparam int THR_W  = 12;

  // Raster geometry
  localparam int LINE_PIXELS  = 1920;
  localparam int FRAME_LINES  = 1200;
  localparam int FRAME_PIX_I  = LINE_PIXELS * FRAME_LINES;
  localparam int LONG_RAST_I  = LINE_PIXELS - LINE_PIXELS / 16;

  localparam logic [RC_W-1:0]  LINE_RC      = RC_W'(LINE_PIXELS);
  localparam logic [RC_W-1:0]  LONG_RC      = RC_W'(LONG_RAST_I);
  localparam logic [RC_W-1:0]  RC_MAX       = {RC_W{1'b1}};
  localparam logic [OFF_W-1:0] FRAME_PIXELS = OFF_W'(FRAME_PIX_I);

  // Stream codes
  localparam logic [BYTE_W-1:0] CODE_EOR   = 8'h80;
  localparam int                RUN_BIT    = 7;
  localparam logic [COL_W-1:0]  PAD_COLOUR = '0;

  // Register reset value
  localparam logic [THR_W-1:0] BLANK_THR_RST = THR_W'(100);

endpackage

### src/raster_rle_video_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_rle_video_decoder_core: run-length video stream to frame writes
// Turns each stream byte into at most one frame buffer write command.
// ----------------------------------------------------------------------------
// One stream byte is taken per clock while in_stall is low. Each accepted byte
// is held in an input register, then a single pass of logic updates the
// decoder state and loads the result register, so a write command (start,
// length, colour) or a frame done beat shows on the ports
// from that register. The result
// register parts the two channels: a byte is still taken while a result
// waits, and in_stall rises only when both the input register and a stalled
// result register are full. After frame done all further bytes are taken
// and dropped until reset. cfg_wr_data sets the vertical blank threshold and
// must be written only while the decoder is idle.
module raster_rle_video_decoder_core
  import rrle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // stream bytes
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_code_byte,
  // write commands
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OFF_W-1:0]  out_write_start,
  output logic [LEN_W-1:0]  out_write_length,
  output logic [COL_W-1:0]  out_write_colour,
  output logic              out_frame_done,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [THR_W-1:0]  cfg_wr_data
);

  logic [THR_W-1:0]  blank_thr_r;
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;

  logic [OFF_W-1:0]  frame_offset_r, frame_offset_nxt;
  logic [RC_W-1:0]   raster_count_r, raster_count_nxt;
  logic [COL_W-1:0]  held_colour_r,  held_colour_nxt;
  logic              drawing_r,      drawing_nxt;
  logic              blank_r,        blank_nxt;
  logic              first_r,        first_nxt;
  logic              finished_r,     finished_nxt;

  logic              out_valid_r;
  logic [OFF_W-1:0]  out_start_r;
  logic [LEN_W-1:0]  out_length_r;
  logic [COL_W-1:0]  out_colour_r;
  logic              out_done_r;

  logic              advance;
  logic              blank_hit;
  logic              res_vld;
  logic              res_done;
  logic              em_req;
  logic [LEN_W-1:0]  em_len;
  logic [COL_W-1:0]  em_col;
  logic [OFF_W-1:0]  em_base;
  logic [OFF_W-1:0]  room;
  logic [LEN_W-1:0]  clip_len;
  logic [RC_W:0]     rc_sum;
  logic [RC_W-1:0]   excess;
  logic [COL_W-1:0]  reps;

  // process the held beat when the result register is free or draining
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  assign blank_hit = !first_r && (raster_count_r < RC_W'(blank_thr_r)) && !blank_r;
  assign reps      = in_byte_r[COL_W-1:0] - COL_W'(1);
  assign rc_sum    = {1'b0, raster_count_r} + (RC_W+1)'(reps);
  assign excess    = raster_count_r - LINE_RC;

  always_comb begin
    frame_offset_nxt = frame_offset_r;
    raster_count_nxt = raster_count_r;
    held_colour_nxt  = held_colour_r;
    drawing_nxt      = drawing_r;
    blank_nxt        = blank_r;
    first_nxt        = first_r;
    finished_nxt     = finished_r;
    res_vld          = 1'b0;
    res_done         = 1'b0;
    em_req           = 1'b0;
    em_len           = '0;
    em_col           = PAD_COLOUR;
    em_base          = frame_offset_r;

    if (!finished_r) begin
      priority if (in_byte_r == CODE_EOR) begin
        if (blank_hit && drawing_r) begin
          finished_nxt = 1'b1;
          res_vld      = 1'b1;
          res_done     = 1'b1;
        end else begin
          if (blank_hit) begin
            drawing_nxt = 1'b1;
            blank_nxt   = 1'b1;
            em_base     = '0;
          end
          first_nxt = 1'b0;
          if (raster_count_r >= LONG_RC) begin
            blank_nxt = 1'b0;
          end
          frame_offset_nxt = em_base;
          // pad short rasters, rewind long ones
          if (raster_count_r < LINE_RC) begin
            em_req = 1'b1;
            em_len = LEN_W'(LINE_RC - raster_count_r);
          end else if (raster_count_r > LINE_RC) begin
            frame_offset_nxt = (em_base > OFF_W'(excess)) ?
                               em_base - OFF_W'(excess) : '0;
          end
          raster_count_nxt = '0;
        end
      end else if (in_byte_r[RUN_BIT]) begin
        raster_count_nxt = rc_sum[RC_W] ? RC_MAX : rc_sum[RC_W-1:0];
        em_req = drawing_r;
        em_len = LEN_W'(reps);
        em_col = held_colour_r;
      end else begin
        held_colour_nxt = in_byte_r[COL_W-1:0];
        if (raster_count_r != RC_MAX) begin
          raster_count_nxt = raster_count_r + RC_W'(1);
        end
        em_req = drawing_r;
        em_len = LEN_W'(1);
        em_col = in_byte_r[COL_W-1:0];
      end
    end

    // clip at the frame end
    room     = (FRAME_PIXELS > em_base) ? FRAME_PIXELS - em_base : '0;
    clip_len = (room < OFF_W'(em_len)) ? room[LEN_W-1:0] : em_len;
    if (em_req && (clip_len != '0)) begin
      res_vld          = 1'b1;
      frame_offset_nxt = em_base + OFF_W'(clip_len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_thr_r    <= BLANK_THR_RST;
      in_valid_r     <= 1'b0;
      frame_offset_r <= '0;
      raster_count_r <= '0;
      held_colour_r  <= '0;
      drawing_r      <= 1'b0;
      blank_r        <= 1'b0;
      first_r        <= 1'b1;
      finished_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        blank_thr_r <= cfg_wr_data;
      end
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        frame_offset_r <= frame_offset_nxt;
        raster_count_r <= raster_count_nxt;
        held_colour_r  <= held_colour_nxt;
        drawing_r      <= drawing_nxt;
        blank_r        <= blank_nxt;
        first_r        <= first_nxt;
        finished_r     <= finished_nxt;
      end
      if (advance && res_vld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte_r <= in_code_byte;
    end
    if (advance && res_vld) begin
      out_start_r  <= res_done ? frame_offset_r : em_base;
      out_length_r <= res_done ? '0 : clip_len;
      out_colour_r <= res_done ? PAD_COLOUR : em_col;
      out_done_r   <= res_done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_start  = out_start_r;
  assign out_write_length = out_length_r;
  assign out_write_colour = out_colour_r;
  assign out_frame_done   = out_done_r;

endmodule

### src/rrle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrle_checker: port checks for the raster RLE video decoder
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module rrle_checker
  import rrle_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [OFF_W-1:0]  out_write_start,
  input logic [LEN_W-1:0]  out_write_length,
  input logic [COL_W-1:0]  out_write_colour,
  input logic              out_frame_done
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_write_start) &&
      $stable(out_write_length) && $stable(out_write_colour) &&
      $stable(out_frame_done))
    else $error("stalled result beat changed");

  // frame done carries no pixels
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_write_length == '0 &&
      out_write_colour == PAD_COLOUR)
    else $error("frame done beat carries a write");

  // every write beat writes something, never past the frame end
  a_write_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_done |-> out_write_length != '0 &&
      out_write_start < FRAME_PIXELS &&
      OFF_W'(out_write_length) <= FRAME_PIXELS - out_write_start)
    else $error("write beat empty or past frame end");

  // input is only held back while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result side free");

endmodule

bind raster_rle_video_decoder_core rrle_checker u_rrle_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_write_start  (out_write_start),
  .out_write_length (out_write_length),
  .out_write_colour (out_write_colour),
  .out_frame_done   (out_frame_done)
);

### tb/raster_rle_write_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_rle_write_checker: write command predictor and scoreboard
// Watches the byte, command and threshold ports of the decoder. It decodes
// every accepted stream byte into the expected frame buffer write command
// and compares each command beat field by field, in order, with the oldest
// expectation.
// ----------------------------------------------------------------------------
module raster_rle_write_checker
  import rrle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [BYTE_W-1:0] in_code_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [OFF_W-1:0]  out_write_start,
  input  logic [LEN_W-1:0]  out_write_length,
  input  logic [COL_W-1:0]  out_write_colour,
  input  logic              out_frame_done,
  input  logic              cfg_wr_en,
  input  logic [THR_W-1:0]  cfg_wr_data,
  output int                fail_count,
  output int                cmds_pending,
  output int                cmds_checked
);

  typedef struct packed {
    logic [OFF_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic [COL_W-1:0] colour;
    logic             done;
  } write_cmd_t;

  write_cmd_t write_cmd_q[$];

  logic [THR_W-1:0] blank_thr;
  logic [OFF_W-1:0] frame_off;
  logic [RC_W-1:0]  line_cnt;
  logic [COL_W-1:0] held_col;
  logic             drawing;
  logic             in_blank;
  logic             first_line;
  logic             decode_done;

  int mismatches = 0;
  int checked    = 0;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] write command mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Clip at the frame end; a fully clipped write gives no beat.
  task automatic queue_write(input int unsigned len, input logic [COL_W-1:0] colour);
    int unsigned room;
    write_cmd_t  cmd;
    room = (FRAME_PIX_I > frame_off) ? FRAME_PIX_I - frame_off : 0;
    if (len > room) len = room;
    if (len == 0) return;
    cmd.start  = frame_off;
    cmd.len    = LEN_W'(len);
    cmd.colour = colour;
    cmd.done   = 1'b0;
    write_cmd_q.push_back(cmd);
    frame_off = frame_off + OFF_W'(len);
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    int unsigned cnt;
    int unsigned excess;
    int unsigned reps;
    write_cmd_t  cmd;
    cnt = line_cnt;
    if (decode_done) return;
    if (b == CODE_EOR) begin
      if (!first_line && cnt < blank_thr && !in_blank) begin
        // a second blank while drawing closes the frame
        if (drawing) begin
          decode_done = 1'b1;
          cmd.start   = frame_off;
          cmd.len     = '0;
          cmd.colour  = '0;
          cmd.done    = 1'b1;
          write_cmd_q.push_back(cmd);
          return;
        end
        drawing   = 1'b1;
        frame_off = '0;
        in_blank  = 1'b1;
      end
      first_line = 1'b0;
      if (cnt >= LONG_RAST_I) in_blank = 1'b0;
      if (cnt < LINE_PIXELS) begin
        queue_write(LINE_PIXELS - cnt, PAD_COLOUR);
      end else if (cnt > LINE_PIXELS) begin
        // rewind by the excess, stopping at zero
        excess    = cnt - LINE_PIXELS;
        frame_off = (frame_off > excess) ? frame_off - OFF_W'(excess) : '0;
      end
      line_cnt = '0;
    end else if (b[RUN_BIT]) begin
      reps = int'(b[COL_W-1:0]) - 1;
      cnt  = cnt + reps;
      if (cnt > RC_MAX) cnt = RC_MAX;
      line_cnt = RC_W'(cnt);
      if (drawing) queue_write(reps, held_col);
    end else begin
      held_col = b[COL_W-1:0];
      if (line_cnt != RC_MAX) line_cnt = line_cnt + 1'b1;
      if (drawing) queue_write(1, held_col);
    end
  endtask

  always @(posedge clk) begin
    write_cmd_t head;
    if (!rst_n) begin
      blank_thr   = BLANK_THR_RST;
      frame_off   = '0;
      line_cnt    = '0;
      held_col    = '0;
      drawing     = 1'b0;
      in_blank    = 1'b0;
      first_line  = 1'b1;
      decode_done = 1'b0;
      write_cmd_q.delete();
    end else begin
      // check the command beat before decoding this edge's byte
      if (out_valid && !out_stall) begin
        if (write_cmd_q.size() == 0) begin
          flag_mismatch($sformatf("beat with nothing pending: start %0d len %0d done %0b",
                                  out_write_start, out_write_length, out_frame_done));
        end else begin
          head = write_cmd_q.pop_front();
          checked++;
          if (out_write_start !== head.start)
            flag_mismatch($sformatf("write_start %0d, expected %0d",
                                    out_write_start, head.start));
          if (out_write_length !== head.len)
            flag_mismatch($sformatf("write_length %0d, expected %0d",
                                    out_write_length, head.len));
          if (out_write_colour !== head.colour)
            flag_mismatch($sformatf("write_colour %0d, expected %0d",
                                    out_write_colour, head.colour));
          if (out_frame_done !== head.done)
            flag_mismatch($sformatf("frame_done %0b, expected %0b",
                                    out_frame_done, head.done));
        end
      end
      if (in_valid && !in_stall) decode_byte(in_code_byte);
      if (cfg_wr_en) blank_thr = cfg_wr_data;
    end
    fail_count   <= mismatches;
    cmds_pending <= write_cmd_q.size();
    cmds_checked <= checked;
  end

endmodule

### tb/raster_rle_video_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_rle_video_decoder_core_tb: stream stimulus and verdict
// Feeds the decoder a directed opening (blank arming, padding, runs, long
// rasters and a rewind that stops at zero), random framed and unframed
// streams under several blank thresholds, a frame end fill with clipping, and
// finally frame done. The checker beside the block predicts and compares every
// write command.
// ----------------------------------------------------------------------------
module raster_rle_video_decoder_core_tb;
  import rrle_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] in_code_byte;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [OFF_W-1:0]  out_write_start;
  logic [LEN_W-1:0]  out_write_length;
  logic [COL_W-1:0]  out_write_colour;
  logic              out_frame_done;
  logic              cfg_wr_en;
  logic [THR_W-1:0]  cfg_wr_data;

  int fail_count;
  int cmds_pending;
  int cmds_checked;

  bit idling_on    = 1'b0;
  int bytes_sent   = 0;
  int line_count   = 0;
  int line_ends    = 0;
  int thr_settings = 0;
  int thr_now;

  raster_rle_video_decoder_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_code_byte     (in_code_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_start  (out_write_start),
    .out_write_length (out_write_length),
    .out_write_colour (out_write_colour),
    .out_frame_done   (out_frame_done),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  raster_rle_write_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_code_byte     (in_code_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_start  (out_write_start),
    .out_write_length (out_write_length),
    .out_write_colour (out_write_colour),
    .out_frame_done   (out_frame_done),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .fail_count       (fail_count),
    .cmds_pending     (cmds_pending),
    .cmds_checked     (cmds_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= idling_on && ($urandom_range(0, 99) < 11);
  end

  function automatic logic [BYTE_W-1:0] colour_byte(input int c);
    return {1'b0, COL_W'(c)};
  endfunction

  function automatic logic [BYTE_W-1:0] run_byte(input int n);
    return {1'b1, COL_W'(n)};
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (idling_on && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_code_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    // track the raster length so that no short raster ends a frame early
    if (b == CODE_EOR) begin
      line_count = 0;
      line_ends++;
    end else if (b[RUN_BIT]) begin
      line_count += int'(b[COL_W-1:0]) - 1;
    end else begin
      line_count++;
    end
  endtask

  task automatic end_line();
    while (line_count < thr_now) send_byte(run_byte($urandom_range(2, 127)));
    send_byte(CODE_EOR);
  endtask

  // Hold until every command is out and the pipeline has drained.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (cmds_pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_threshold(input int v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= THR_W'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    thr_now = v;
    thr_settings++;
  endtask

  task automatic random_raster();
    int kind;
    int n;
    int target;
    logic [BYTE_W-1:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      n = $urandom_range(0, 8);
      repeat (n) begin
        if ($urandom_range(0, 1)) send_byte(colour_byte($urandom_range(0, 127)));
        else send_byte(run_byte($urandom_range(1, 127)));
      end
      end_line();
    end else if (kind < 85) begin
      // near or past one line: ends the blank period or rewinds the offset
      target = $urandom_range(1700, 2200);
      while (line_count < target) begin
        if ($urandom_range(0, 7) == 0) send_byte(colour_byte($urandom_range(0, 127)));
        else send_byte(run_byte($urandom_range(1, 127)));
      end
      end_line();
    end else begin
      // unframed bytes: the raster just carries on
      n = $urandom_range(1, 6);
      repeat (n) begin
        b = BYTE_W'($urandom_range(0, 255));
        if (b == CODE_EOR) end_line();
        else send_byte(b);
      end
    end
  endtask

  task automatic random_phase(input int n_bytes);
    int stop;
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) random_raster();
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_code_byte <= '0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    thr_now = BLANK_THR_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // before drawing is armed: pixels and runs write nothing, first raster pads
    send_byte(colour_byte(0));
    send_byte(colour_byte(127));
    send_byte(run_byte(1));
    send_byte(run_byte(127));
    send_byte(CODE_EOR);
    // a raster of over two lines rewinds past zero and stops there
    repeat (35) send_byte(run_byte(127));
    send_byte(colour_byte(126));
    send_byte(CODE_EOR);
    // empty raster is vertical blank: arm drawing
    send_byte(CODE_EOR);
    send_byte(colour_byte(42));
    send_byte(run_byte(1));
    send_byte(run_byte(2));
    send_byte(run_byte(127));
    send_byte(CODE_EOR);
    // blank again while still in the blank period: no frame done
    send_byte(CODE_EOR);
    // long raster ends the blank period
    send_byte(colour_byte(127));
    repeat (15) send_byte(run_byte(127));
    send_byte(CODE_EOR);

    set_threshold(0);
    random_phase(40);
    idling_on = 1'b1;
    random_phase(30);
    set_threshold($urandom_range(1, 127));
    random_phase(30);
    set_threshold($urandom_range(128, 2047));
    random_phase(40);

    // fill up to the frame end; later writes clip partly or fully
    set_threshold(0);
    while (line_ends < FRAME_LINES + 10) send_byte(CODE_EOR);
    send_byte(colour_byte(64));
    send_byte(run_byte(16));
    repeat (16) send_byte(run_byte(127));
    send_byte(CODE_EOR);
    send_byte(colour_byte(51));
    send_byte(run_byte(127));

    // short raster after the blank period closes the frame
    set_threshold((1 << THR_W) - 1);
    send_byte(colour_byte(17));
    send_byte(CODE_EOR);
    repeat (4) send_byte(BYTE_W'($urandom_range(0, 255)));
    settle();

    $display("Decoded %0d stream bytes under %0d threshold settings, %0d commands checked.",
             bytes_sent, thr_settings, cmds_checked);
    if (fail_count == 0) begin
      $display("** raster_rle_video_decoder_core: PASSED **");
    end else begin
      $display("** raster_rle_video_decoder_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run timed out with %0d commands outstanding.", cmds_pending);
    $display("** raster_rle_video_decoder_core: FAILED **");
    $finish;
  end

endmodule
